@@ design/kriq_pkg.sv @@
// Package with shared types and constants of the key and rotary input qualifier.
`timescale 1ns / 1ps

package kriq_pkg;

  // Item kind carried on the input tuser field; code 3 has no meaning.
  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_NONLATCHING   = 2'd0,
    CFG_PRESS_MASK    = 2'd1,
    CFG_HOLD_VOLUME   = 2'd2,
    CFG_LOCKOUT_TICKS = 2'd3
  } cfg_index_t;

  // Quadrature step tables, indexed by {old B, old A, new B, new A}.
  localparam logic [15:0] STEP_NEXT_TABLE = 16'b0010100000010100;
  localparam logic [15:0] STEP_PREV_TABLE = 16'b0100000110000010;

  localparam logic [7:0] LOCKOUT_TICKS_RESET = 8'd64;
  localparam int unsigned NUM_KEYS = 3;

  // Input item as held in the input register (kind plus pin levels).
  typedef struct packed {
    logic [1:0] kind;
    logic       rot_b_level;
    logic       rot_a_level;
    logic       key_b_level;
    logic       key_a_level;
    logic       button_level;
  } in_item_t;

  // Result item; the last member sits in the lowest bits.
  typedef struct packed {
    logic       locked_out;
    logic       sample_taken;
    logic       volume_down;
    logic       volume_up;
    logic [7:0] press_count;
    logic       rotary_prev_flag;
    logic       rotary_next_flag;
    logic       latched_key_b;
    logic       latched_key_a;
    logic       latched_button;
  } result_t;

endpackage

@@ design/key_and_rotary_input_qualifier_core.sv @@
// Top level of the key and rotary input qualifier: input register, step logic, result register.
`timescale 1ns / 1ps

// The block accepts one item per clock while out_tready does not stall it, and returns exactly
// one result item for each. An accepted item is held in the input register and then moves into
// the result register, which drives out_tvalid, once that register is empty or being taken.
// Between the two registers lies combinational decode (key latches, press count, quadrature
// table lookup, lockout counter) that updates the state and loads the result register. While
// a result waits for out_tready, one more item can still be taken into the input register if
// that register is empty. A pin sample (kind 0) is ignored while the lockout counter runs, a
// tick (kind 1) counts the lockout down, and a restart (kind 2) clears latches, press count,
// rotary history and lockout. Configuration writes are always ready and should be made while
// no item is in flight.
module key_and_rotary_input_qualifier_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] button_level, [1] key_a_level, [2] key_b_level,
                                  // [3] rot_a_level, [4] rot_b_level, [7:5] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] latched_button, [1] latched_key_a,
                                  // [2] latched_key_b, [3] rotary_next_flag,
                                  // [4] rotary_prev_flag, [12:5] press_count,
                                  // [13] volume_up, [14] volume_down,
                                  // [15] sample_taken, [16] locked_out, [23:17] zero
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Configuration registers
  logic       cfg_nonlatching_r;
  logic [2:0] cfg_press_mask_r;
  logic       cfg_hold_volume_r;
  logic [7:0] cfg_lockout_ticks_r;

  // Input register
  logic               in_valid_r;
  kriq_pkg::in_item_t in_item_r;

  // Block state
  logic [4:0] latch_bits_r, latch_bits_nxt;
  logic [1:0] old_rotary_r, old_rotary_nxt;
  logic [7:0] press_counter_r, press_counter_nxt;
  logic [7:0] lockout_left_r, lockout_left_nxt;

  // Result register
  logic              out_valid_r;
  kriq_pkg::result_t result_r, result_nxt;

  logic            advance;
  logic            fire;
  logic            in_fire;
  kriq_pkg::kind_t kind;
  logic [2:0]      key_pressed;
  logic [1:0]      press_add;
  logic [3:0]      step_vec;
  logic            step_next;
  logic            step_prev;
  logic            sample_ok;
  logic            active;
  logic            vol_up;
  logic            vol_down;

  // Handshakes: the result register frees up when empty or taken this cycle.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_nonlatching_r   <= 1'b0;
      cfg_press_mask_r    <= 3'd0;
      cfg_hold_volume_r   <= 1'b0;
      cfg_lockout_ticks_r <= kriq_pkg::LOCKOUT_TICKS_RESET;
    end else if (cfg_valid) begin
      unique case (kriq_pkg::cfg_index_t'(cfg_index))
        kriq_pkg::CFG_NONLATCHING:   cfg_nonlatching_r   <= cfg_data[0];
        kriq_pkg::CFG_PRESS_MASK:    cfg_press_mask_r    <= cfg_data[2:0];
        kriq_pkg::CFG_HOLD_VOLUME:   cfg_hold_volume_r   <= cfg_data[0];
        kriq_pkg::CFG_LOCKOUT_TICKS: cfg_lockout_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.kind         <= in_tuser;
      in_item_r.button_level <= in_tdata[0];
      in_item_r.key_a_level  <= in_tdata[1];
      in_item_r.key_b_level  <= in_tdata[2];
      in_item_r.rot_a_level  <= in_tdata[3];
      in_item_r.rot_b_level  <= in_tdata[4];
    end
  end

  // Per-item decode: keys, press count, quadrature step and lockout.
  always_comb begin
    kind        = kriq_pkg::kind_t'(in_item_r.kind);
    key_pressed = ~{in_item_r.key_b_level, in_item_r.key_a_level, in_item_r.button_level};
    press_add   = 2'({1'b0, key_pressed[0] & cfg_press_mask_r[0]})
                + 2'({1'b0, key_pressed[1] & cfg_press_mask_r[1]})
                + 2'({1'b0, key_pressed[2] & cfg_press_mask_r[2]});
    step_vec    = {old_rotary_r, in_item_r.rot_b_level, in_item_r.rot_a_level};
    step_next   = kriq_pkg::STEP_NEXT_TABLE[step_vec];
    step_prev   = !step_next && kriq_pkg::STEP_PREV_TABLE[step_vec];
    sample_ok   = (lockout_left_r == 8'd0);
    active      = (|key_pressed) || step_next || step_prev;
    vol_up      = 1'b0;
    vol_down    = 1'b0;

    latch_bits_nxt    = latch_bits_r;
    old_rotary_nxt    = old_rotary_r;
    press_counter_nxt = press_counter_r;
    lockout_left_nxt  = lockout_left_r;

    unique case (kind)
      kriq_pkg::KIND_SAMPLE: begin
        if (sample_ok) begin
          for (int k = 0; k < kriq_pkg::NUM_KEYS; k++) begin
            if (key_pressed[k]) begin
              latch_bits_nxt[k] = 1'b1;
            end else if (cfg_nonlatching_r) begin
              latch_bits_nxt[k] = 1'b0;
            end
          end
          press_counter_nxt = press_counter_r + 8'(press_add);
          if (cfg_hold_volume_r) begin
            if (step_next) latch_bits_nxt[3] = 1'b1;
            if (step_prev) latch_bits_nxt[4] = 1'b1;
          end else begin
            vol_up   = step_next;
            vol_down = step_prev;
          end
          if (active) lockout_left_nxt = cfg_lockout_ticks_r;
          old_rotary_nxt = step_vec[1:0];
        end
      end
      kriq_pkg::KIND_TICK: begin
        if (!sample_ok) lockout_left_nxt = lockout_left_r - 8'd1;
      end
      kriq_pkg::KIND_RESTART: begin
        latch_bits_nxt    = 5'd0;
        old_rotary_nxt    = 2'd0;
        press_counter_nxt = 8'd0;
        lockout_left_nxt  = 8'd0;
      end
      default: ;
    endcase

    // Result shows the state after the item.
    result_nxt.latched_button   = latch_bits_nxt[0];
    result_nxt.latched_key_a    = latch_bits_nxt[1];
    result_nxt.latched_key_b    = latch_bits_nxt[2];
    result_nxt.rotary_next_flag = latch_bits_nxt[3];
    result_nxt.rotary_prev_flag = latch_bits_nxt[4];
    result_nxt.press_count      = press_counter_nxt;
    result_nxt.volume_up        = vol_up;
    result_nxt.volume_down      = vol_down;
    result_nxt.sample_taken     = (kind == kriq_pkg::KIND_SAMPLE) && sample_ok;
    result_nxt.locked_out       = (lockout_left_nxt != 8'd0);
  end

  // State update, once per item that moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_bits_r    <= 5'd0;
      old_rotary_r    <= 2'd0;
      press_counter_r <= 8'd0;
      lockout_left_r  <= 8'd0;
    end else if (fire) begin
      latch_bits_r    <= latch_bits_nxt;
      old_rotary_r    <= old_rotary_nxt;
      press_counter_r <= press_counter_nxt;
      lockout_left_r  <= lockout_left_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, result_r};

  // A sample seen with no lockout running is reported as taken.
  a_sample_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_item_r.kind == kriq_pkg::KIND_SAMPLE && lockout_left_r == 8'd0)
      |=> result_r.sample_taken)
    else $error("pin sample with idle lockout not reported as taken");

  // Forward and backward volume pulses never come together.
  a_vol_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(result_r.volume_up && result_r.volume_down))
    else $error("volume up and down pulsed in one result");

  // In hold mode rotary steps never pulse the volume outputs.
  a_hold_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cfg_hold_volume_r) |=> (!result_r.volume_up && !result_r.volume_down))
    else $error("volume pulse while holding rotary steps");

  // A restart leaves counters and latches cleared.
  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_item_r.kind == kriq_pkg::KIND_RESTART)
      |=> (lockout_left_r == 8'd0 && press_counter_r == 8'd0 && latch_bits_r == 5'd0))
    else $error("restart did not clear the state");

  // The reported lockout flag follows the lockout counter.
  a_locked_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (result_r.locked_out == (lockout_left_r != 8'd0)))
    else $error("locked_out flag disagrees with lockout counter");

endmodule
